/* sv/tgc_pkg.sv */
`timescale 1ns / 1ps

package tgc_pkg;

    // Fixed field widths of the event and result words
    localparam int unsigned OP_W      = 2;
    localparam int unsigned ID_W      = 8;
    localparam int unsigned POS_W     = 12;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned GESTURE_W = 3;
    localparam int unsigned ACTIVE_W  = 4;
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 16;

    localparam int unsigned THR_W  = 12;
    localparam int unsigned LONG_W = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CMP_W  = 16;

    localparam int unsigned DEF_MAX_POINTS = 8;
    localparam int unsigned DEF_COORD_BITS = 12;

    localparam logic [THR_W-1:0]  SWIPE_DEFAULT = THR_W'(40);
    localparam logic [LONG_W-1:0] LONG_DEFAULT  = LONG_W'(500);
    localparam logic [TIME_W-1:0] DTAP_WINDOW   = TIME_W'(300);

    typedef enum logic [OP_W-1:0] {
        OP_DOWN = 2'd0,
        OP_MOVE = 2'd1,
        OP_UP   = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [GESTURE_W-1:0] {
        G_NONE  = 3'd0,
        G_TAP   = 3'd1,
        G_DTAP  = 3'd2,
        G_LEFT  = 3'd3,
        G_RIGHT = 3'd4,
        G_UP    = 3'd5,
        G_DOWN  = 3'd6,
        G_LONG  = 3'd7
    } t_gesture;

    typedef enum logic [0:0] {
        REG_SWIPE = 1'b0,
        REG_LONG  = 1'b1
    } t_cfg_reg;

endpackage

/* sv/tgc_ram.sv */
`timescale 1ns / 1ps

module tgc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tgc_classify.sv */
`timescale 1ns / 1ps

module tgc_classify
    import tgc_pkg::*;
#(
    parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
    input  logic [COORD_BITS-1:0] i_adx,
    input  logic [COORD_BITS-1:0] i_ady,
    input  logic                  i_x_gt,      // current x above start x
    input  logic                  i_y_gt,      // current y above start y
    input  logic [TIME_W-1:0]     i_hold,      // now minus down time
    input  logic [TIME_W-1:0]     i_gap,       // down time minus last tap
    input  logic [THR_W-1:0]      i_swipe_thr,
    input  logic [LONG_W-1:0]     i_long_time,
    output t_gesture              o_gesture,
    output logic                  o_tap_like
);

    logic w_small;

    assign w_small = (CMP_W'(i_adx) < CMP_W'(i_swipe_thr)) &&
                     (CMP_W'(i_ady) < CMP_W'(i_swipe_thr));
    assign o_tap_like = w_small;

    always_comb begin
        priority if (w_small) begin
            priority if (i_hold >= TIME_W'(i_long_time)) begin
                o_gesture = G_LONG;
            end else if (i_gap < DTAP_WINDOW) begin
                o_gesture = G_DTAP;
            end else begin
                o_gesture = G_TAP;
            end
        end else if (i_adx > i_ady) begin
            o_gesture = i_x_gt ? G_RIGHT : G_LEFT;
        end else begin
            o_gesture = i_y_gt ? G_DOWN : G_UP;
        end
    end

endmodule

/* sv/touch_gesture_classifier_top.sv */
`timescale 1ns / 1ps
// Channel  Dir  Handshake               Word
// s        in   i_s_tvalid/o_s_tready   i_s_tdata: op, contact_id, x_pos, y_pos, now_time
// m        out  o_m_tvalid/i_m_tready   o_m_tdata: status, gesture, active_count
// cfg      in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Flow: one word at a time. Down and ignored ops go from accept straight to DONE;
// move searches the table for the matching contact and then goes to DONE, and up
// searches, shifts the entries after the match down, then classifies. The contact
// table is one RAM with a registered read port: the search reads one entry per
// cycle and the compaction after an up moves one entry per cycle.
// Reset (i_rst_n low, synchronous) empties the table, clears the last tap time
// and loads the default thresholds; table contents are not cleared.
// Stalls: a held result in the output register does not block the next accept;
// a finished word waits in DONE only while the output register is still full.

module touch_gesture_classifier_top
    import tgc_pkg::*;
#(
    parameter int unsigned MAX_POINTS = DEF_MAX_POINTS,
    parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [1:0] op, [9:2] contact_id, [21:10] x_pos, [33:22] y_pos, [65:34] now_time
    input  logic [IN_DATA_W-1:0]   i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [1:0] status, [4:2] gesture, [8:5] active_count
    output logic [OUT_DATA_W-1:0]  o_m_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);
    localparam int unsigned IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CB   = COORD_BITS;
    // Entry layout: id, start x, start y, current x, current y, down time
    localparam int unsigned SX_LO = ID_W;
    localparam int unsigned SY_LO = SX_LO + CB;
    localparam int unsigned CX_LO = SY_LO + CB;
    localparam int unsigned CY_LO = CX_LO + CB;
    localparam int unsigned DT_LO = CY_LO + CB;
    localparam int unsigned EW    = DT_LO + TIME_W;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SEARCH   = 5'b00010,
        S_SHIFT    = 5'b00100,
        S_CLASSIFY = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Latched event word
    t_op                r_op, n_op;
    logic [ID_W-1:0]    r_id, n_id;
    logic [CB-1:0]      r_x, n_x;
    logic [CB-1:0]      r_y, n_y;
    logic [TIME_W-1:0]  r_now, n_now;

    logic [CNTW-1:0]    r_count, n_count;
    logic [CNTW-1:0]    r_ptr, n_ptr;
    logic [TIME_W-1:0]  r_last_tap, n_last_tap;
    t_status            r_status, n_status;
    t_gesture           r_gesture, n_gesture;

    // Classifier operands captured at the match
    logic [CB-1:0]      r_adx, n_adx;
    logic [CB-1:0]      r_ady, n_ady;
    logic               r_x_gt, n_x_gt;
    logic               r_y_gt, n_y_gt;
    logic [TIME_W-1:0]  r_hold, n_hold;
    logic [TIME_W-1:0]  r_gap, n_gap;

    logic [THR_W-1:0]   r_swipe_thr;
    logic [LONG_W-1:0]  r_long_time;

    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic               w_s_acc;
    logic               w_out_load;
    logic               w_ram_we;
    logic [IW-1:0]      w_waddr;
    logic [EW-1:0]      w_wdata;
    logic [CNTW:0]      w_raddr_ext;
    logic [EW-1:0]      w_rdata;
    logic [CNTW-1:0]    w_ptr_inc;

    logic [ID_W-1:0]    w_rd_id;
    logic [CB-1:0]      w_rd_sx, w_rd_sy, w_rd_cx, w_rd_cy;
    logic [TIME_W-1:0]  w_rd_dt;

    t_op                w_in_op;
    logic [CB-1:0]      w_in_x, w_in_y;
    t_gesture           w_cls_gesture;
    logic               w_cls_tap;

    assign w_in_op = t_op'(i_s_tdata[1:0]);
    // Keep the low COORD_BITS bits of the coordinate fields
    assign w_in_x  = CB'(i_s_tdata[21:10]);
    assign w_in_y  = CB'(i_s_tdata[33:22]);

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    assign w_rd_id = w_rdata[ID_W-1:0];
    assign w_rd_sx = w_rdata[SX_LO +: CB];
    assign w_rd_sy = w_rdata[SY_LO +: CB];
    assign w_rd_cx = w_rdata[CX_LO +: CB];
    assign w_rd_cy = w_rdata[CY_LO +: CB];
    assign w_rd_dt = w_rdata[DT_LO +: TIME_W];

    assign w_ptr_inc = r_ptr + CNTW'(1);

    tgc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_POINTS),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_ext[IW-1:0]),
        .o_rdata (w_rdata)
    );

    tgc_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .i_adx       (r_adx),
        .i_ady       (r_ady),
        .i_x_gt      (r_x_gt),
        .i_y_gt      (r_y_gt),
        .i_hold      (r_hold),
        .i_gap       (r_gap),
        .i_swipe_thr (r_swipe_thr),
        .i_long_time (r_long_time),
        .o_gesture   (w_cls_gesture),
        .o_tap_like  (w_cls_tap)
    );

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_x        = r_x;
        n_y        = r_y;
        n_now      = r_now;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_last_tap = r_last_tap;
        n_status   = r_status;
        n_gesture  = r_gesture;
        n_adx      = r_adx;
        n_ady      = r_ady;
        n_x_gt     = r_x_gt;
        n_y_gt     = r_y_gt;
        n_hold     = r_hold;
        n_gap      = r_gap;

        w_ram_we    = 1'b0;
        w_waddr     = r_ptr[IW-1:0];
        w_wdata     = w_rdata;
        w_raddr_ext = '0;

        unique case (r_state)
            S_IDLE: begin
                // Read slot 0 ahead so the search starts with data in hand
                w_raddr_ext = '0;
                if (w_s_acc) begin
                    n_op      = w_in_op;
                    n_id      = i_s_tdata[9:2];
                    n_x       = w_in_x;
                    n_y       = w_in_y;
                    n_now     = i_s_tdata[65:34];
                    n_gesture = G_NONE;
                    n_status  = ST_OK;
                    n_ptr     = '0;
                    n_state   = S_DONE;
                    unique case (w_in_op)
                        OP_DOWN: begin
                            if (r_count >= CNTW'(MAX_POINTS)) begin
                                n_status = ST_FULL;
                            end else begin
                                // Append at the end of the table
                                w_ram_we = 1'b1;
                                w_waddr  = r_count[IW-1:0];
                                w_wdata  = {i_s_tdata[65:34], w_in_y, w_in_x,
                                            w_in_y, w_in_x, i_s_tdata[9:2]};
                                n_count  = r_count + CNTW'(1);
                            end
                        end
                        OP_MOVE, OP_UP: begin
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                // Data for r_ptr is here; prefetch the next slot
                w_raddr_ext = {1'b0, w_ptr_inc};
                priority if (w_rd_id == r_id) begin
                    if (r_op == OP_MOVE) begin
                        w_ram_we = 1'b1;
                        w_wdata  = {w_rd_dt, r_y, r_x, w_rd_sy, w_rd_sx, w_rd_id};
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else begin
                        n_adx   = (w_rd_cx > w_rd_sx) ? (w_rd_cx - w_rd_sx)
                                                      : (w_rd_sx - w_rd_cx);
                        n_ady   = (w_rd_cy > w_rd_sy) ? (w_rd_cy - w_rd_sy)
                                                      : (w_rd_sy - w_rd_cy);
                        n_x_gt  = w_rd_cx > w_rd_sx;
                        n_y_gt  = w_rd_cy > w_rd_sy;
                        n_hold  = r_now - w_rd_dt;
                        n_gap   = w_rd_dt - r_last_tap;
                        n_state = S_SHIFT;
                    end
                end else if (w_ptr_inc >= r_count) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    n_ptr = w_ptr_inc;
                end
            end

            S_SHIFT: begin
                // Data for r_ptr + 1 is here; move it down and prefetch two ahead
                w_raddr_ext = {1'b0, r_ptr} + (CNTW + 1)'(2);
                if (w_ptr_inc < r_count) begin
                    w_ram_we = 1'b1;
                    w_wdata  = w_rdata;
                    n_ptr    = w_ptr_inc;
                end else begin
                    n_count = r_count - CNTW'(1);
                    n_state = S_CLASSIFY;
                end
            end

            S_CLASSIFY: begin
                n_gesture = w_cls_gesture;
                n_status  = ST_OK;
                if (w_cls_tap) begin
                    n_last_tap = r_now;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                // Hold until the output register is free
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_last_tap  <= '0;
            r_out_valid <= 1'b0;
            r_swipe_thr <= SWIPE_DEFAULT;
            r_long_time <= LONG_DEFAULT;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_last_tap <= n_last_tap;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            // A zero write selects the default value
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_SWIPE: begin
                        r_swipe_thr <= (i_cfg_data[THR_W-1:0] == '0) ? SWIPE_DEFAULT
                                                                     : i_cfg_data[THR_W-1:0];
                    end
                    REG_LONG: begin
                        r_long_time <= (i_cfg_data == '0) ? LONG_DEFAULT : i_cfg_data;
                    end
                    default: begin
                        r_long_time <= r_long_time;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_id      <= n_id;
        r_x       <= n_x;
        r_y       <= n_y;
        r_now     <= n_now;
        r_ptr     <= n_ptr;
        r_status  <= n_status;
        r_gesture <= n_gesture;
        r_adx     <= n_adx;
        r_ady     <= n_ady;
        r_x_gt    <= n_x_gt;
        r_y_gt    <= n_y_gt;
        r_hold    <= n_hold;
        r_gap     <= n_gap;
        if (w_out_load) begin
            r_out_data <= {7'd0, ACTIVE_W'(r_count), r_gesture, r_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Table never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_POINTS))
        else $error("contact count above table depth");

    // A down event with room grows the table by one
    a_down_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (w_in_op == OP_DOWN) && (r_count < CNTW'(MAX_POINTS)))
        |=> (r_count == $past(r_count) + CNTW'(1)))
        else $error("down event did not append a contact");

    // Compaction ends by shrinking the table by one
    a_up_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SHIFT) && !(w_ptr_inc < r_count))
        |=> (r_count == $past(r_count) - CNTW'(1)))
        else $error("up event did not remove a contact");

    // A result is loaded only into a free or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_out_valid) |-> i_m_tready)
        else $error("result register overwritten");

endmodule
